// ----- rtl/ca_pkg.sv -----
// Shared constants and controller-to-datapath command and status types.
package ca_pkg;

    localparam int ADDR_W      = 6;
    localparam int STORE_DEPTH = 64;
    localparam int SAMPLE_W    = 16;
    localparam int PROD_W      = 2 * SAMPLE_W;
    localparam int SUM_W       = 39;
    localparam int BLOCK_LEN_DEFAULT = 64;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              issue;
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_b;
        logic              first;
        logic              load;
        logic [ADDR_W-1:0] lag;
        logic              last;
    } ca_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;
    } ca_status_t;

endpackage

// ----- rtl/circular_autocorrelation.sv -----
// Top level of the circular autocorrelation block.
// Samples arrive one transaction each and are stored; in_ready stays high while a
// block fills. The BLOCK_LEN-th sample starts the computation of all BLOCK_LEN lags
// with one shared 16x16 multiply-accumulate fed by a two-read-port sample store: each
// lag reads all BLOCK_LEN sample pairs, drains the pipeline and then loads its sum into
// the output register, waiting there while an earlier result is still held. Results come
// out in increasing lag order with last_lag set on lag BLOCK_LEN-1; input is not
// accepted until the last lag is in the output register, after which the next block can
// fill while that result waits.
module circular_autocorrelation
    import ca_pkg::*;
#(
    parameter int BLOCK_LEN = BLOCK_LEN_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [ADDR_W-1:0]          lag,
    output logic signed [SUM_W-1:0]    corr_sum,
    output logic                       last_lag
);

    ca_cmd_t    cmd;
    ca_status_t status;

    ca_ctrl #(
        .BLOCK_LEN (BLOCK_LEN)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    ca_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .lag       (lag),
        .corr_sum  (corr_sum),
        .last_lag  (last_lag)
    );

endmodule

// ----- rtl/ca_datapath.sv -----
// Sample store, multiply-accumulate pipeline and output register.
module ca_datapath
    import ca_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  ca_cmd_t                    cmd,
    output ca_status_t                 status,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [ADDR_W-1:0]          lag,
    output logic signed [SUM_W-1:0]    corr_sum,
    output logic                       last_lag
);

    logic signed [SAMPLE_W-1:0] mem [STORE_DEPTH];

    logic signed [SAMPLE_W-1:0] a_reg;
    logic signed [SAMPLE_W-1:0] b_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SUM_W-1:0]    acc_reg;
    logic                       v1_reg;
    logic                       f1_reg;
    logic                       v2_reg;
    logic                       f2_reg;
    logic                       out_valid_reg;
    logic [ADDR_W-1:0]          lag_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic                       last_reg;
    logic signed [SUM_W-1:0]    prod_ext;

    // Sample store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= sample;
        end
        if (cmd.issue)
        begin
            a_reg <= mem[cmd.addr_a];
            b_reg <= mem[cmd.addr_b];
        end
    end

    // Product stage and accumulator
    always_ff @(posedge clk)
    begin
        prod_reg <= a_reg * b_reg;
        f2_reg   <= f1_reg;
        if (v2_reg)
        begin
            acc_reg <= f2_reg ? prod_ext : acc_reg + prod_ext;
        end
    end

    assign prod_ext = {{(SUM_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    // Pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            f1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            f1_reg <= cmd.first;
            v2_reg <= v1_reg;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lag_reg  <= cmd.lag;
            sum_reg  <= acc_reg;
            last_reg <= cmd.last;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign lag             = lag_reg;
    assign corr_sum        = sum_reg;
    assign last_lag        = last_reg;

endmodule

// ----- rtl/ca_ctrl.sv -----
// Controller: sample fill count, lag and index sequencing, result hand-off.
module ca_ctrl
    import ca_pkg::*;
#(
    parameter int BLOCK_LEN = BLOCK_LEN_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  ca_status_t status,
    output ca_cmd_t    cmd
);

    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(BLOCK_LEN - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_LOAD
    } state_t;

    state_t            state_reg,   state_next;
    logic [ADDR_W-1:0] fill_reg,    fill_next;
    logic [ADDR_W-1:0] lag_reg,     lag_next;
    logic [ADDR_W-1:0] idx_reg,     idx_next;
    logic [ADDR_W-1:0] jdx_reg,     jdx_next;
    logic [1:0]        drain_reg,   drain_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        lag_next   = lag_reg;
        idx_next   = idx_reg;
        jdx_next   = jdx_reg;
        drain_next = drain_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.wr_addr = fill_reg;
        cmd.addr_a  = idx_reg;
        cmd.addr_b  = jdx_reg;
        cmd.lag     = lag_reg;
        cmd.last    = (lag_reg == LAST_IDX);
        case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.wr_en = in_valid;
                if (in_valid)
                begin
                    if (fill_reg == LAST_IDX)
                    begin
                        fill_next  = '0;
                        lag_next   = '0;
                        idx_next   = '0;
                        jdx_next   = '0;
                        state_next = S_RUN;
                    end
                    else
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                end
            end
            S_RUN:
            begin
                cmd.issue = 1'b1;
                cmd.first = (idx_reg == '0);
                idx_next  = idx_reg + 1'b1;
                jdx_next  = (jdx_reg == LAST_IDX) ? '0 : jdx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    drain_next = '0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == 2'd2)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.load = 1'b1;
                    if (lag_reg == LAST_IDX)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        lag_next   = lag_reg + 1'b1;
                        idx_next   = '0;
                        jdx_next   = lag_reg + 1'b1;
                        state_next = S_RUN;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            lag_reg   <= '0;
            idx_reg   <= '0;
            jdx_reg   <= '0;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            lag_reg   <= lag_next;
            idx_reg   <= idx_next;
            jdx_reg   <= jdx_next;
            drain_reg <= drain_next;
        end
    end

    logic [ADDR_W:0] wrap_sum;
    assign wrap_sum = {1'b0, idx_reg} + {1'b0, lag_reg};

`ifndef ASSERT_OFF
    // second read index is always (i + lag) mod N while reading
    a_jdx_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RUN |->
            ((wrap_sum >= (ADDR_W+1)'(BLOCK_LEN))
                ? (jdx_reg == ADDR_W'(wrap_sum - (ADDR_W+1)'(BLOCK_LEN)))
                : (jdx_reg == wrap_sum[ADDR_W-1:0])))
        else $error("read index b out of step with lag");

    // completing sample starts the computation with a cleared fill count
    a_block_start: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE && in_valid && fill_reg == LAST_IDX |=>
            state_reg == S_RUN && fill_reg == '0 && lag_reg == '0 && idx_reg == '0)
        else $error("block computation did not start cleanly");

    // a result is never loaded over one still waiting
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> status.out_free && state_reg == S_LOAD)
        else $error("result loaded while output register busy");
`endif

endmodule
